@@ design/assert_macros.svh @@
// assertion macros used by the allocator top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define NFCA_ASSERT_IMPLIES(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("allocator check failed");

// condition implies consequence in the next cycle
`define NFCA_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("allocator check failed");

// condition implies a delayed consequence
`define NFCA_ASSERT_DELAY2(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> ##2 (c)) \
        else $error("allocator check failed");

`endif

@@ design/nfca_pkg.sv @@
// types and constants of the next-fit channel allocator
package nfca_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 256;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CHANNEL_LIMIT = 255;
    localparam int LIM           = (CHANNEL_LIMIT < TABLE_DEPTH) ? CHANNEL_LIMIT : TABLE_DEPTH;
    localparam int CMP_W         = IDX_W + 1;
    localparam int CNT_W         = $clog2(LIM + 1);
    localparam logic [CMP_W-1:0] LIM_X = CMP_W'(LIM);

    // owner tags
    localparam int OWNER_BITS = 16;

    // two-level free map search
    localparam int GRP_IDX_W  = 4;
    localparam int GROUP_W    = 1 << GRP_IDX_W;
    localparam int NGRP_W     = IDX_W - GRP_IDX_W;
    localparam int NUM_GROUPS = TABLE_DEPTH / GROUP_W;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_TAKE   = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_CHANNEL = 2'd1,
        STAT_NOT_FOUND  = 2'd2,
        STAT_INVALID    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  channel_number;
        logic [15:0] owner_tag;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  granted_channel;
        logic [15:0] found_owner;
        logic [7:0]  channels_in_use;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/nfca_ram.sv @@
// generic single-write, single-read ram with registered read data
module nfca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/nfca_ctrl.sv @@
// sequencer of the allocator: accept, scan, execute, emit
module nfca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nfca_pkg::t_dp_stat i_stat,
    output nfca_pkg::t_dp_cmd  o_cmd
);
    import nfca_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: n_state = ST_EXEC;
            ST_EXEC: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cmd.capture    = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.scan       = (r_state == ST_SCAN);
    assign o_cmd.exec       = (r_state == ST_EXEC);
    assign o_cmd.load_out   = (r_state == ST_EMIT) && i_stat.out_free;

endmodule

@@ design/nfca_dp.sv @@
// allocator datapath: valid map, count, owner ram, free search, output register
module nfca_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nfca_pkg::t_in_item  i_in_item,
    input  nfca_pkg::t_dp_cmd   i_cmd,
    output nfca_pkg::t_dp_stat  o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output nfca_pkg::t_out_item o_out_item
);
    import nfca_pkg::*;

    t_in_item               r_item;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [CNT_W-1:0]       r_used;
    logic [CNT_W-1:0]       n_used;
    t_out_item              r_res;
    t_out_item              n_res;
    t_out_item              r_out_item;
    logic                   r_out_valid;

    // per-group search summaries
    logic                 r_hi_any [NUM_GROUPS];
    logic [GRP_IDX_W-1:0] r_hi_idx [NUM_GROUPS];
    logic                 r_lo_any [NUM_GROUPS];
    logic [GRP_IDX_W-1:0] r_lo_idx [NUM_GROUPS];
    logic                 n_hi_any [NUM_GROUPS];
    logic [GRP_IDX_W-1:0] n_hi_idx [NUM_GROUPS];
    logic                 n_lo_any [NUM_GROUPS];
    logic [GRP_IDX_W-1:0] n_lo_idx [NUM_GROUPS];

    logic [TABLE_DEPTH-1:0] w_free_hi;
    logic [TABLE_DEPTH-1:0] w_free_lo;
    logic [CMP_W-1:0]       w_used_ext;
    logic [CMP_W-1:0]       w_ch_ext;
    logic [CMP_W-1:0]       w_used_next_ext;

    logic                   w_hit;
    logic [IDX_W-1:0]       w_alloc_ch;
    logic                   w_claim;
    logic [IDX_W-1:0]       w_claim_ch;
    logic [OWNER_BITS-1:0]  w_rdata;

    assign w_used_ext = CMP_W'(r_used);
    assign w_ch_ext   = CMP_W'(r_item.channel_number);

    // free map split into the part above the count and the wrap part
    always_comb begin
        for (int c = 0; c < TABLE_DEPTH; c++) begin
            w_free_hi[c] = !r_valid[c] && (CMP_W'(c) < LIM_X) && (CMP_W'(c) > w_used_ext);
            w_free_lo[c] = !r_valid[c] && (CMP_W'(c) < LIM_X) && (c != 0)
                           && (CMP_W'(c) <= w_used_ext);
        end
    end

    // lowest free entry within each group
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_hi_any[g] = 1'b0;
            n_hi_idx[g] = '0;
            n_lo_any[g] = 1'b0;
            n_lo_idx[g] = '0;
            for (int b = GROUP_W - 1; b >= 0; b--) begin
                if (w_free_hi[g * GROUP_W + b]) begin
                    n_hi_any[g] = 1'b1;
                    n_hi_idx[g] = GRP_IDX_W'(b);
                end
                if (w_free_lo[g * GROUP_W + b]) begin
                    n_lo_any[g] = 1'b1;
                    n_lo_idx[g] = GRP_IDX_W'(b);
                end
            end
        end
    end

    // lowest group with a free entry, above the count first, then wrapped
    always_comb begin
        w_hit      = 1'b0;
        w_alloc_ch = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (r_lo_any[g]) begin
                w_hit      = 1'b1;
                w_alloc_ch = {NGRP_W'(g), r_lo_idx[g]};
            end
        end
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (r_hi_any[g]) begin
                w_hit      = 1'b1;
                w_alloc_ch = {NGRP_W'(g), r_hi_idx[g]};
            end
        end
    end

    // command execution
    always_comb begin
        n_valid    = r_valid;
        n_used     = r_used;
        w_claim    = 1'b0;
        w_claim_ch = r_item.channel_number;
        n_res      = '{status: STAT_OK, granted_channel: '0, found_owner: '0,
                       channels_in_use: '0};
        case (r_item.command)
            CMD_ALLOC: begin
                if ((w_used_ext >= LIM_X) || !w_hit) begin
                    n_res.status = STAT_NO_CHANNEL;
                end else begin
                    w_claim    = 1'b1;
                    w_claim_ch = w_alloc_ch;
                    n_res.granted_channel = w_alloc_ch;
                end
            end
            CMD_TAKE: begin
                if ((r_item.channel_number == '0) || (w_ch_ext >= LIM_X)) begin
                    n_res.status = STAT_INVALID;
                end else begin
                    w_claim = 1'b1;
                    n_res.granted_channel = r_item.channel_number;
                end
            end
            CMD_FREE: begin
                if ((r_item.channel_number == '0) || !r_valid[r_item.channel_number]) begin
                    n_res.status = STAT_NOT_FOUND;
                end else begin
                    n_valid[r_item.channel_number] = 1'b0;
                    n_used = r_used - CNT_W'(1);
                    n_res.granted_channel = r_item.channel_number;
                end
            end
            CMD_LOOKUP: begin
                if (!r_valid[r_item.channel_number]) begin
                    n_res.status = STAT_NOT_FOUND;
                end else begin
                    n_res.granted_channel = r_item.channel_number;
                    n_res.found_owner     = 16'(w_rdata);
                end
            end
            default: n_res.status = STAT_NOT_FOUND;
        endcase
        // claim marks the entry valid and counts a newly used channel
        if (w_claim) begin
            if (!r_valid[w_claim_ch]) begin
                n_used = r_used + CNT_W'(1);
            end
            n_valid[w_claim_ch] = 1'b1;
        end
        w_used_next_ext       = CMP_W'(n_used);
        n_res.channels_in_use = w_used_next_ext[7:0];
    end

    // owner table
    nfca_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && w_claim),
        .i_waddr (w_claim_ch),
        .i_wdata (OWNER_BITS'(r_item.owner_tag)),
        .i_re    (i_cmd.scan),
        .i_raddr (r_item.channel_number),
        .o_rdata (w_rdata)
    );

    // item capture, search summaries and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.scan) begin
            r_hi_any <= n_hi_any;
            r_hi_idx <= n_hi_idx;
            r_lo_any <= n_lo_any;
            r_lo_idx <= n_lo_idx;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
        if (i_cmd.load_out) begin
            r_out_item <= r_res;
        end
    end

    // valid map, count and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_valid <= n_valid;
                r_used  <= n_used;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

@@ design/next_fit_channel_allocator_top.sv @@
// Next-fit channel allocator: an item is accepted in idle, then scan, execute and emit follow.
// Scan, execute and emit follow acceptance; emit loads the output register once it is free.
// The sequencer around the two-level free-map search takes a new item only back in idle.
// A new item is accepted while a finished result still waits in the output register.
// Reset (synchronous, active low) clears the valid map, the count and the output valid.
// The owner ram is not cleared; its data is used only for valid channels, written when claimed.
`include "assert_macros.svh"

module next_fit_channel_allocator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nfca_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nfca_pkg::t_out_item o_out_item
);
    import nfca_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    nfca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    nfca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // checks
    `NFCA_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, !o_in_ready)
    `NFCA_ASSERT_DELAY2(a_exec_follows_accept, i_in_valid && o_in_ready, w_cmd.exec)
    `NFCA_ASSERT_IMPLIES(a_fail_no_channel, o_out_valid && (o_out_item.status != STAT_OK), (o_out_item.granted_channel == '0) && (o_out_item.found_owner == '0))
    `NFCA_ASSERT_IMPLIES(a_count_in_range, o_out_valid, {1'b0, o_out_item.channels_in_use} <= LIM_X)

endmodule

@@ tb/next_fit_channel_allocator_top_test.sv @@
// self-checking testbench for the next-fit channel allocator with owner table
`timescale 1ns / 100ps

module next_fit_channel_allocator_top_test;
    import nfca_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_LOAD = 320;
    localparam int CHUNK          = 4;
    localparam int TOP_CHANNEL    = LIM - 1;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // stimulus and scoreboard state
    t_in_item  pending_cmds[$];
    t_out_item expected_replies[$];
    bit        in_taken;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        mismatch_count;
    int        cycle_count;

    // predicted allocator state
    bit          chan_used[TABLE_DEPTH];
    logic [15:0] chan_owner[TABLE_DEPTH];
    int          live_count;

    next_fit_channel_allocator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // mark a channel as owned and record its tag
    function automatic void claim_channel(int ch, logic [15:0] tag);
        if (!chan_used[ch]) begin
            chan_used[ch] = 1'b1;
            live_count++;
        end
        chan_owner[ch] = tag;
    endfunction

    // next-fit allocation, ownership and lookup on the predicted table
    function automatic t_out_item predict_reply(t_in_item cmd_item);
        t_out_item rep;
        int        ch;
        int        c;
        int        hit;
        ch  = int'(cmd_item.channel_number);
        hit = 0;
        rep = '{status: STAT_OK, granted_channel: 8'd0, found_owner: 16'd0,
                channels_in_use: 8'd0};
        case (cmd_item.command)
            CMD_ALLOC: begin
                if (live_count < LIM) begin
                    for (c = live_count + 1; c < LIM && hit == 0; c++)
                        if (!chan_used[c]) hit = c;
                    // wrap search includes the channel equal to the count
                    for (c = 1; c <= live_count && c < LIM && hit == 0; c++)
                        if (!chan_used[c]) hit = c;
                end
                if (hit == 0) begin
                    rep.status = STAT_NO_CHANNEL;
                end else begin
                    claim_channel(hit, cmd_item.owner_tag);
                    rep.granted_channel = 8'(hit);
                end
            end
            CMD_TAKE: begin
                if (ch < 1 || ch >= LIM) begin
                    rep.status = STAT_INVALID;
                end else begin
                    claim_channel(ch, cmd_item.owner_tag);
                    rep.granted_channel = 8'(ch);
                end
            end
            CMD_FREE: begin
                if (ch < 1 || !chan_used[ch]) begin
                    rep.status = STAT_NOT_FOUND;
                end else begin
                    chan_used[ch] = 1'b0;
                    live_count--;
                    rep.granted_channel = 8'(ch);
                end
            end
            default: begin
                if (!chan_used[ch]) begin
                    rep.status = STAT_NOT_FOUND;
                end else begin
                    rep.granted_channel = 8'(ch);
                    rep.found_owner     = chan_owner[ch];
                end
            end
        endcase
        rep.channels_in_use = 8'(live_count);
        return rep;
    endfunction

    // pick a channel that is currently owned, or any channel when none is
    function automatic int pick_owned_channel();
        int start;
        int k;
        int c;
        start = $urandom_range(TOP_CHANNEL, 1);
        for (k = 0; k < TOP_CHANNEL; k++) begin
            c = 1 + (start - 1 + k) % TOP_CHANNEL;
            if (chan_used[c]) return c;
        end
        return start;
    endfunction

    function automatic void queue_cmd(t_cmd cmd, int ch, int tag);
        t_in_item it;
        it.command        = cmd;
        it.channel_number = 8'(ch);
        it.owner_tag      = 16'(tag);
        pending_cmds.insert(pending_cmds.size(), it);
    endfunction

    function automatic void report_failure(string msg);
        if (mismatch_count < 10) $display("%s", msg);
        mismatch_count++;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                i_in_item  <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        if (i_rst_n) i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // monitor: check results and predict accepted items on the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    report_failure($sformatf(
                        "unexpected result: status=%0d ch=%0d owner=%h cnt=%0d",
                        o_out_item.status, o_out_item.granted_channel,
                        o_out_item.found_owner, o_out_item.channels_in_use));
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out_item.status !== want.status ||
                        o_out_item.granted_channel !== want.granted_channel ||
                        o_out_item.found_owner !== want.found_owner ||
                        o_out_item.channels_in_use !== want.channels_in_use)
                        report_failure($sformatf(
                            {"mismatch: exp status=%0d ch=%0d owner=%h cnt=%0d, ",
                             "got status=%0d ch=%0d owner=%h cnt=%0d"},
                            want.status, want.granted_channel, want.found_owner,
                            want.channels_in_use, o_out_item.status,
                            o_out_item.granted_channel, o_out_item.found_owner,
                            o_out_item.channels_in_use));
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_replies.insert(expected_replies.size(), predict_reply(i_in_item));
                in_taken = 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // stimulus sequence
    initial begin
        int  load;
        int  n;
        int  k;
        int  roll;
        bit  filling;
        int  full_chunks;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        in_taken       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        live_count     = 0;
        filling        = 1'b1;
        full_chunks    = 0;
        foreach (chan_used[i]) chan_used[i] = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-table misses, bad claims, reclaim, frees and lookups
        queue_cmd(CMD_LOOKUP, 0, 0);
        queue_cmd(CMD_FREE, 0, 0);
        queue_cmd(CMD_ALLOC, 0, 16'hFFFF);
        queue_cmd(CMD_ALLOC, 255, 16'h0000);
        queue_cmd(CMD_TAKE, 0, 16'h1111);
        queue_cmd(CMD_TAKE, 255, 16'h2222);
        queue_cmd(CMD_TAKE, TOP_CHANNEL, 16'hA5A5);
        queue_cmd(CMD_TAKE, TOP_CHANNEL, 16'h5A5A);
        queue_cmd(CMD_LOOKUP, TOP_CHANNEL, 0);
        queue_cmd(CMD_LOOKUP, 255, 0);
        queue_cmd(CMD_FREE, 255, 0);
        queue_cmd(CMD_FREE, 1, 0);
        queue_cmd(CMD_FREE, 1, 0);
        queue_cmd(CMD_LOOKUP, 1, 0);
        queue_cmd(CMD_ALLOC, 0, 16'h0F0F);
        queue_cmd(CMD_TAKE, 1, 16'h8001);
        queue_cmd(CMD_LOOKUP, 2, 0);
        queue_cmd(CMD_FREE, TOP_CHANNEL, 0);
        queue_cmd(CMD_FREE, 2, 0);
        queue_cmd(CMD_FREE, 3, 0);
        queue_cmd(CMD_FREE, 1, 0);
        queue_cmd(CMD_ALLOC, 0, 16'h1234);
        queue_cmd(CMD_TAKE, 128, 16'h7FFF);
        queue_cmd(CMD_LOOKUP, 128, 0);
        queue_cmd(CMD_FREE, 128, 0);

        // random: fill to exhaustion, drain, refill, under each idle and stall load
        for (load = 0; load < 4; load++) begin
            // hold off until the table is quiet
            while (pending_cmds.size() != 0 || i_in_valid || expected_replies.size() != 0)
                @(posedge i_clk);
            case (load)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (n = 0; n < ITEMS_PER_LOAD; n += CHUNK) begin
                while (pending_cmds.size() != 0) @(posedge i_clk);
                if (filling && live_count >= TOP_CHANNEL) full_chunks++;
                if (filling && full_chunks >= 3) begin
                    filling     = 1'b0;
                    full_chunks = 0;
                end else if (!filling && live_count < 8) begin
                    filling = 1'b1;
                end
                for (k = 0; k < CHUNK; k++) begin
                    roll = $urandom_range(99, 0);
                    if (filling ? roll < 4 : roll < 10)
                        queue_cmd(t_cmd'($urandom_range(3, 0)), $urandom_range(255, 0),
                                  $urandom_range(65535, 0));
                    else if (filling ? roll < 74 : roll < 20)
                        queue_cmd(CMD_ALLOC, $urandom_range(255, 0), $urandom_range(65535, 0));
                    else if (filling ? roll < 89 : roll < 25)
                        queue_cmd(CMD_TAKE, $urandom_range(TOP_CHANNEL, 1),
                                  $urandom_range(65535, 0));
                    else if (filling ? roll < 97 : roll < 40)
                        queue_cmd(CMD_LOOKUP, pick_owned_channel(), $urandom_range(65535, 0));
                    else
                        queue_cmd(CMD_FREE, pick_owned_channel(), $urandom_range(65535, 0));
                end
            end
        end

        // drain and let the pipeline settle
        while (pending_cmds.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ next_fit_channel_allocator_top.f @@
+incdir+design
design/nfca_pkg.sv
design/nfca_ram.sv
design/nfca_ctrl.sv
design/nfca_dp.sv
design/next_fit_channel_allocator_top.sv
tb/next_fit_channel_allocator_top_test.sv
